// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PTM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PTM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ptm_pkg.sv -----
package ptm_pkg;

   // Field widths.
   localparam int SAMPLE_W = 12;
   localparam int VALUE_W  = 16;
   localparam int STATUS_W = 3;
   localparam int MODE_W   = 3;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PICKUP_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_HIGH  = 2'd2;

   // Register reset values.
   localparam logic [MODE_W-1:0]         PICKUP_MODE_RESET = 3'd0;
   localparam logic signed [VALUE_W-1:0] RANGE_LOW_RESET   = 16'sd0;
   localparam logic signed [VALUE_W-1:0] RANGE_HIGH_RESET  = 16'sd127;

   // Pickup modes; any code not listed behaves as direct.
   localparam logic [MODE_W-1:0] PM_SNAP     = 3'd1;
   localparam logic [MODE_W-1:0] PM_RELATIVE = 3'd2;
   localparam logic [MODE_W-1:0] PM_PARALLAX = 3'd3;
   localparam logic [MODE_W-1:0] PM_SWITCH   = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_TAKEN     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_HELD      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PARALLAX  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd4;

   // Switch hysteresis thresholds at 30% and 70% of full scale.
   localparam logic [SAMPLE_W-1:0] SWITCH_LOW  = 12'((32'h1000 * 30) / 100);
   localparam logic [SAMPLE_W-1:0] SWITCH_HIGH = 12'((32'h1000 * 70) / 100);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 12'hfff;

   // Serial divider operand width and step count.
   localparam int DIV_W     = 17;
   localparam int DIV_STEPS = DIV_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // Saturate a wide signed value to the 16-bit value range.
   function automatic logic signed [VALUE_W-1:0] sat16(input logic signed [19:0] x);
      logic signed [VALUE_W-1:0] r;
      if (x > 20'sd32767) begin
         r = 16'sh7fff;
      end else if (x < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = x[15:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/pot_takeover_mode_mapper.sv -----
// A load or a held-back switch sample goes from S_IDLE to S_DONE; a pot sample passes S_SCALE_V,
// S_SCALE_P and S_DECIDE, a parallax approach then S_DIV (the 17-step serial divider) and S_ADJ
// when it divides, and S_PAR. S_DONE loads the result register once it is free; requests stall
// until S_IDLE. One shared 8x17 multiplier scales the new and then the previous sample.
// Reset (synchronous, active high) restores the registers to their defaults, clears
// the stored value, the previous sample and the external flag, and drops any pending result.
`include "assert_macros.svh"

module pot_takeover_mode_mapper (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic [ptm_pkg::SAMPLE_W-1:0]          req_pot_sample,
   input  logic signed [ptm_pkg::VALUE_W-1:0]    req_loaded_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ptm_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                  rsp_send,
   output logic signed [ptm_pkg::VALUE_W-1:0]    rsp_stored_value,
   output logic signed [ptm_pkg::VALUE_W-1:0]    rsp_approach_value,
   input  logic                                  csr_write,
   input  logic [ptm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ptm_pkg::VALUE_W-1:0]           csr_data
);
   import ptm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SCALE_V, S_SCALE_P, S_DECIDE, S_DIV, S_ADJ, S_PAR, S_DONE
   } state_type;

   // Configuration registers.
   logic [MODE_W-1:0]         pickup_mode_ff;
   logic signed [VALUE_W-1:0] range_low_ff;
   logic signed [VALUE_W-1:0] range_high_ff;

   // Persistent state.
   logic [SAMPLE_W-1:0]       last_sample_ff;
   logic signed [VALUE_W-1:0] current_value_ff;
   logic                      external_flag_ff;

   // Sequencer and working registers.
   state_type                 state_ff;
   logic [SAMPLE_W-1:0]       s_ff;
   logic [SAMPLE_W-1:0]       p_ff;
   logic signed [17:0]        v_ff;
   logic signed [17:0]        pv_ff;
   logic [DIV_W-1:0]          div_quo_ff;
   logic [DIV_W-1:0]          div_rem_ff;
   logic [DIV_W-1:0]          div_den_ff;
   logic [CNT_W-1:0]          div_count_ff;
   logic                      q_neg_ff;
   logic signed [19:0]        appr_ff;
   logic [STATUS_W-1:0]       res_status_ff;
   logic                      res_send_ff;
   logic signed [VALUE_W-1:0] res_approach_ff;

   // Result register.
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic                      rsp_send_ff;
   logic signed [VALUE_W-1:0] rsp_stored_ff;
   logic signed [VALUE_W-1:0] rsp_approach_ff;

   // Span orientation and width.
   logic                      asc;
   logic signed [17:0]        span_wide;
   logic [16:0]               span;
   logic signed [VALUE_W-1:0] lo;
   logic signed [VALUE_W-1:0] top;

   // Shared scaling multiplier.
   logic [7:0]                mul_q;
   logic [24:0]               prod;
   logic [16:0]               prod_hi;
   logic signed [17:0]        scaled;

   // Decision terms.
   logic signed [17:0]        cur18;
   logic signed [18:0]        diff;
   logic                      diff_neg;
   logic                      v_eq_cur;
   logic signed [19:0]        nv;
   logic signed [19:0]        nv_clamped;
   logic signed [18:0]        top_minus_v;
   logic signed [17:0]        top_minus_cur;
   logic                      tmv_pos;
   logic                      par_up;
   logic                      par_dn;
   logic                      div_needed;
   logic signed [17:0]        div_num;
   logic signed [18:0]        div_den;
   logic [17:0]               num_abs;
   logic [18:0]               den_abs;
   logic [STATUS_W-1:0]       plain_status;
   logic signed [19:0]        take_val;
   logic signed [VALUE_W-1:0] take_sat;

   // Switch hysteresis on the incoming sample.
   logic                      sw_fall;
   logic                      sw_rise;

   // Divider step.
   logic [DIV_W:0]            div_shift;
   logic [DIV_W+1:0]          div_trial;
   logic                      div_fits;
   logic signed [19:0]        q_ext;
   logic signed [VALUE_W-1:0] appr_sat;

   logic                      req_accept;
   logic                      rsp_free;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_send           = rsp_send_ff;
   assign rsp_stored_value   = rsp_stored_ff;
   assign rsp_approach_value = rsp_approach_ff;

   // Span: low end, high end and width plus one in either orientation.
   assign asc       = (range_low_ff <= range_high_ff);
   assign span_wide = asc ? (18'(range_high_ff) - 18'(range_low_ff) + 18'sd1)
                          : (18'(range_low_ff) - 18'(range_high_ff) + 18'sd1);
   assign span      = span_wide[16:0];
   assign lo        = asc ? range_low_ff : range_high_ff;
   assign top       = asc ? range_high_ff : range_low_ff;

   // The multiplier scales the new sample first, then the previous one.
   assign mul_q   = (state_ff == S_SCALE_V) ? s_ff[11:4] : p_ff[11:4];
   assign prod    = 25'(mul_q) * 25'(span);
   assign prod_hi = prod[24:8];
   assign scaled  = asc ? (18'(range_low_ff) + $signed({1'b0, prod_hi}))
                        : (18'(range_low_ff) - $signed({1'b0, prod_hi}));

   // Comparisons of the scaled values against the stored value.
   assign cur18         = 18'(current_value_ff);
   assign diff          = 19'(v_ff) - 19'(pv_ff);
   assign diff_neg      = diff[18];
   assign v_eq_cur      = (v_ff == cur18);
   assign top_minus_v   = 19'(top) - 19'(v_ff);
   assign top_minus_cur = 18'(top) - cur18;
   assign tmv_pos       = !top_minus_v[18] && (top_minus_v != '0);
   assign par_up = external_flag_ff && !diff_neg && ((pv_ff > cur18) || (v_ff < cur18));
   assign par_dn = external_flag_ff && diff_neg && ((pv_ff < cur18) || (v_ff > cur18));
   assign div_needed = (par_up && tmv_pos) || (par_dn && (v_ff != '0));

   // Relative mode: add the movement and clamp on the side it moves toward.
   assign nv = 20'(current_value_ff) + 20'(diff);
   always_comb begin
      if (!diff_neg) begin
         nv_clamped = (nv >= 20'(top)) ? 20'(top) : nv;
      end else begin
         nv_clamped = (nv < 20'(lo)) ? 20'(lo) : nv;
      end
   end

   // Status and takeover value for every case that is not a parallax approach.
   always_comb begin
      take_val = 20'(v_ff);
      case (pickup_mode_ff)
         PM_SNAP: begin
            if (v_eq_cur) begin
               plain_status = ST_UNCHANGED;
            end else if (par_up || par_dn) begin
               plain_status = ST_HELD;
            end else begin
               plain_status = ST_TAKEN;
            end
         end
         PM_RELATIVE: begin
            plain_status = ST_TAKEN;
            take_val     = nv_clamped;
         end
         default: begin
            plain_status = v_eq_cur ? ST_UNCHANGED : ST_TAKEN;
         end
      endcase
   end
   assign take_sat = sat16(take_val);

   // Divider operands: signed numerator and denominator reduced to magnitudes.
   assign div_num = par_up ? top_minus_cur : cur18;
   assign div_den = par_up ? top_minus_v : 19'(v_ff);
   assign num_abs = div_num[17] ? 18'(-div_num) : 18'(div_num);
   assign den_abs = div_den[18] ? 19'(-div_den) : 19'(div_den);

   // One restoring division step per cycle.
   assign div_shift = {div_rem_ff, div_quo_ff[DIV_W-1]};
   assign div_trial = {1'b0, div_shift} - {2'b00, div_den_ff};
   assign div_fits  = !div_trial[DIV_W+1];

   assign q_ext    = $signed(20'(div_quo_ff));
   assign appr_sat = sat16(appr_ff);

   // Switch mode watches crossings of the hysteresis thresholds.
   assign sw_fall = (last_sample_ff >= SWITCH_LOW) && (req_pot_sample < SWITCH_LOW);
   assign sw_rise = (last_sample_ff < SWITCH_HIGH) && (req_pot_sample >= SWITCH_HIGH);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pickup_mode_ff <= PICKUP_MODE_RESET;
         range_low_ff   <= RANGE_LOW_RESET;
         range_high_ff  <= RANGE_HIGH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PICKUP_MODE: pickup_mode_ff <= csr_data[MODE_W-1:0];
            CSR_RANGE_LOW:   range_low_ff   <= $signed(csr_data);
            CSR_RANGE_HIGH:  range_high_ff  <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // Sequencer, state update and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         last_sample_ff   <= '0;
         current_value_ff <= '0;
         external_flag_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         div_count_ff     <= '0;
      end else begin
         // A taken result leaves unless the next one replaces it in this cycle.
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  res_send_ff     <= 1'b0;
                  res_approach_ff <= '0;
                  if (req_mode) begin
                     current_value_ff <= req_loaded_value;
                     external_flag_ff <= 1'b1;
                     res_status_ff    <= ST_LOADED;
                     state_ff         <= S_DONE;
                  end else begin
                     last_sample_ff <= req_pot_sample;
                     if (pickup_mode_ff == PM_SWITCH) begin
                        if (sw_fall) begin
                           s_ff     <= '0;
                           p_ff     <= SAMPLE_MAX;
                           state_ff <= S_SCALE_V;
                        end else if (sw_rise) begin
                           s_ff     <= SAMPLE_MAX;
                           p_ff     <= '0;
                           state_ff <= S_SCALE_V;
                        end else begin
                           res_status_ff <= ST_HELD;
                           state_ff      <= S_DONE;
                        end
                     end else begin
                        s_ff     <= req_pot_sample;
                        p_ff     <= last_sample_ff;
                        state_ff <= S_SCALE_V;
                     end
                  end
               end
            end
            S_SCALE_V: begin
               v_ff     <= scaled;
               state_ff <= S_SCALE_P;
            end
            S_SCALE_P: begin
               pv_ff    <= scaled;
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if ((pickup_mode_ff == PM_PARALLAX) && (par_up || par_dn)) begin
                  if (div_needed) begin
                     div_quo_ff   <= num_abs[DIV_W-1:0];
                     div_rem_ff   <= '0;
                     div_den_ff   <= den_abs[DIV_W-1:0];
                     div_count_ff <= '0;
                     q_neg_ff     <= div_num[17] ^ div_den[18] ^ par_dn;
                     state_ff     <= S_DIV;
                  end else begin
                     appr_ff  <= 20'(v_ff);
                     state_ff <= S_PAR;
                  end
               end else begin
                  res_status_ff <= plain_status;
                  if (plain_status == ST_TAKEN) begin
                     current_value_ff <= take_sat;
                     res_send_ff      <= 1'b1;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DIV: begin
               div_rem_ff <= div_fits ? div_trial[DIV_W-1:0] : div_shift[DIV_W-1:0];
               div_quo_ff <= {div_quo_ff[DIV_W-2:0], div_fits};
               if (div_count_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= S_ADJ;
               end else begin
                  div_count_ff <= div_count_ff + 1'b1;
               end
            end
            S_ADJ: begin
               appr_ff  <= 20'(current_value_ff) + (q_neg_ff ? -q_ext : q_ext);
               state_ff <= S_PAR;
            end
            S_PAR: begin
               res_status_ff   <= ST_PARALLAX;
               res_approach_ff <= appr_sat;
               res_send_ff     <= !appr_sat[VALUE_W-1];
               state_ff        <= S_DONE;
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= res_status_ff;
                  rsp_send_ff     <= res_send_ff;
                  rsp_stored_ff   <= current_value_ff;
                  rsp_approach_ff <= res_approach_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // An accepted transaction always starts work in the next cycle.
   `PTM_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != S_IDLE, "accepted transaction left the sequencer idle")
   // The division never runs past its step count.
   `PTM_ASSERT_IMP(a_div_count, clock, reset, state_ff == S_DIV, div_count_ff < CNT_W'(DIV_STEPS), "divider step count overran")
   // Held-back and loaded results never request a send.
   `PTM_ASSERT_IMP(a_quiet_status, clock, reset, rsp_valid_ff && (rsp_status_ff == ST_HELD || rsp_status_ff == ST_LOADED), !rsp_send_ff, "send raised on a held or loaded result")
   // Only a parallax approach carries an approach value.
   `PTM_ASSERT_IMP(a_approach_zero, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_PARALLAX), rsp_approach_ff == '0, "approach value set outside parallax")
   // A loaded result implies the external flag is set.
   `PTM_ASSERT_IMP(a_load_sets_flag, clock, reset, rsp_valid_ff && (rsp_status_ff == ST_LOADED), external_flag_ff, "load did not set the external flag")

endmodule

// ----- bench/pot_takeover_mode_mapper_tb.sv -----
module pot_takeover_mode_mapper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ptm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 200;
   localparam int MAX_REPORTS = 10;

   // Highest pickup code that is not assigned; it behaves as direct.
   localparam logic [MODE_W-1:0] PM_SPARE = 3'd7;

   // One input transaction: a pot sample or a load of the stored value.
   typedef struct {
      logic                      mode;
      logic [SAMPLE_W-1:0]       sample;
      logic signed [VALUE_W-1:0] loaded;
   } pot_item_type;

   // One result transaction.
   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic                      send;
      logic signed [VALUE_W-1:0] stored;
      logic signed [VALUE_W-1:0] approach;
   } takeover_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_mode = 1'b0;
   logic [SAMPLE_W-1:0]       req_pot_sample = '0;
   logic signed [VALUE_W-1:0] req_loaded_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      rsp_send;
   logic signed [VALUE_W-1:0] rsp_stored_value;
   logic signed [VALUE_W-1:0] rsp_approach_value;
   logic                      csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [VALUE_W-1:0]        csr_data = '0;

   pot_takeover_mode_mapper i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_pot_sample     (req_pot_sample),
      .req_loaded_value   (req_loaded_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_send           (rsp_send),
      .rsp_stored_value   (rsp_stored_value),
      .rsp_approach_value (rsp_approach_value),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // Mirror of the block's registers and state.
   logic [MODE_W-1:0]   m_pickup = PICKUP_MODE_RESET;
   int                  m_low = 0;
   int                  m_high = 127;
   logic [SAMPLE_W-1:0] m_last_sample = '0;
   int                  m_value = 0;
   bit                  m_external = 1'b0;

   pot_item_type        pot_pending[$];
   takeover_result_type takeover_expected[$];
   pot_item_type        offered_item;
   takeover_result_type want;

   int unsigned send_idle_pct = 13;
   int unsigned recv_idle_pct = 63;
   int unsigned stall_kicks = 0;
   int unsigned stall_seen = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned checked = 0;
   int unsigned fail_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Scale the top 8 bits of a sample into the configured span, which may be reversed.
   function automatic int scale_pot(logic [SAMPLE_W-1:0] s);
      int q;
      q = int'(s[SAMPLE_W-1:4]);
      if (m_low <= m_high) begin
         return m_low + (q * (m_high - m_low + 1)) / 256;
      end
      return m_low - (q * (m_low - m_high + 1)) / 256;
   endfunction

   function automatic int clip16(int x);
      if (x > 32767) begin
         return 32767;
      end
      if (x < -32768) begin
         return -32768;
      end
      return x;
   endfunction

   // Advance the mirrored state by one accepted transaction and return its result.
   function automatic takeover_result_type predict_takeover(pot_item_type it);
      takeover_result_type r;
      logic [SAMPLE_W-1:0] s;
      logic [SAMPLE_W-1:0] p;
      logic [STATUS_W-1:0] st;
      bit                  snd;
      bit                  held;
      int                  v, pv, diff, nv, lo, hi, appr;
      st = ST_TAKEN;
      snd = 1'b0;
      held = 1'b0;
      appr = 0;
      if (it.mode) begin
         m_value = int'(it.loaded);
         m_external = 1'b1;
         st = ST_LOADED;
      end else begin
         s = it.sample;
         p = m_last_sample;
         m_last_sample = s;
         // Switch mode only acts on a crossing of the hysteresis thresholds.
         if (m_pickup == PM_SWITCH) begin
            if (p >= SWITCH_LOW && s < SWITCH_LOW) begin
               s = '0;
               p = SAMPLE_MAX;
            end else if (p < SWITCH_HIGH && s >= SWITCH_HIGH) begin
               s = SAMPLE_MAX;
               p = '0;
            end else begin
               held = 1'b1;
               st = ST_HELD;
            end
         end
         if (!held) begin
            v = scale_pot(s);
            pv = scale_pot(p);
            diff = v - pv;
            lo = (m_low <= m_high) ? m_low : m_high;
            hi = (m_low <= m_high) ? m_high : m_low;
            case (m_pickup)
               PM_SNAP: begin
                  if (v == m_value) begin
                     st = ST_UNCHANGED;
                  end else if (m_external && (diff >= 0 ? (pv > m_value || v < m_value)
                                                        : (pv < m_value || v > m_value))) begin
                     st = ST_HELD;
                  end
               end
               PM_RELATIVE: begin
                  // Clamp only on the side the pot is moving toward.
                  nv = m_value + diff;
                  if (diff >= 0) begin
                     if (nv >= hi) nv = hi;
                  end else if (nv < lo) begin
                     nv = lo;
                  end
                  v = nv;
               end
               PM_PARALLAX: begin
                  if (m_external && diff >= 0 && (pv > m_value || v < m_value)) begin
                     appr = v;
                     if (hi - v > 0) appr = m_value + (hi - m_value) / (hi - v);
                     st = ST_PARALLAX;
                  end else if (m_external && diff < 0 && (pv < m_value || v > m_value)) begin
                     appr = v;
                     if (v != 0) appr = m_value - m_value / v;
                     st = ST_PARALLAX;
                  end else if (v == m_value) begin
                     st = ST_UNCHANGED;
                  end
                  if (st == ST_PARALLAX) begin
                     appr = clip16(appr);
                     snd = (appr >= 0);
                  end
               end
               default: begin
                  if (v == m_value) st = ST_UNCHANGED;
               end
            endcase
            if (st == ST_TAKEN) begin
               m_value = clip16(v);
               snd = 1'b1;
            end
         end
      end
      r.status = st;
      r.send = snd;
      r.stored = m_value[VALUE_W-1:0];
      r.approach = appr[VALUE_W-1:0];
      return r;
   endfunction

   // Driver: offers the next pending transaction once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            takeover_expected.push_back(predict_takeover(offered_item));
         end
         if (!req_valid || !req_stall) begin
            if (pot_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_item = pot_pending.pop_front();
               req_valid <= 1'b1;
               req_mode <= offered_item.mode;
               req_pot_sample <= offered_item.sample;
               req_loaded_value <= offered_item.loaded;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, started on request from the stimulus sequence.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (stall_kicks != stall_seen) begin
         stall_seen <= stall_kicks;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: checks each accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked = checked + 1;
            if (takeover_expected.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= MAX_REPORTS) begin
                  $display("Result %0d arrived with nothing expected: status %0d stored %0d",
                           checked, rsp_status, rsp_stored_value);
               end
            end else begin
               want = takeover_expected.pop_front();
               if (want.status !== rsp_status || want.send !== rsp_send ||
                   want.stored !== rsp_stored_value || want.approach !== rsp_approach_value) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("Result %0d mismatch: status %0d/%0d send %0d/%0d stored %0d/%0d approach %0d/%0d (expected/actual)",
                              checked, want.status, rsp_status, want.send, rsp_send,
                              want.stored, rsp_stored_value, want.approach, rsp_approach_value);
                  end
               end
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic push_sample(input logic [SAMPLE_W-1:0] s);
      pot_item_type it;
      it.mode = 1'b0;
      it.sample = s;
      it.loaded = 16'($urandom);
      pot_pending.push_back(it);
   endtask

   task automatic push_load(input logic signed [VALUE_W-1:0] v);
      pot_item_type it;
      it.mode = 1'b1;
      it.sample = 12'($urandom);
      it.loaded = v;
      pot_pending.push_back(it);
   endtask

   // Wait until every transaction has been taken and its result has come back.
   task automatic wait_quiet;
      do begin
         @(negedge clock);
      end while (pot_pending.size() != 0 || req_valid || takeover_expected.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_PICKUP_MODE: m_pickup = data[MODE_W-1:0];
         CSR_RANGE_LOW:   m_low = int'($signed(data));
         CSR_RANGE_HIGH:  m_high = int'($signed(data));
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [MODE_W-1:0] pm, input logic [VALUE_W-1:0] lo,
                             input logic [VALUE_W-1:0] hi);
      write_csr(CSR_PICKUP_MODE, VALUE_W'(pm));
      write_csr(CSR_RANGE_LOW, lo);
      write_csr(CSR_RANGE_HIGH, hi);
   endtask

   // Pick a pickup mode and a span: full, reversed, narrow in either orientation, random, collapsed or the reset span.
   task automatic random_config;
      int                lo, hi;
      logic [MODE_W-1:0] pm;
      pm = ($urandom_range(9) < 8) ? MODE_W'($urandom_range(4)) : MODE_W'($urandom_range(5, 7));
      case ($urandom_range(6))
         0: begin
            lo = -32768;
            hi = 32767;
         end
         1: begin
            lo = 32767;
            hi = -32768;
         end
         2: begin
            lo = int'($urandom_range(400)) - 200;
            hi = lo + int'($urandom_range(300));
         end
         3: begin
            hi = int'($urandom_range(400)) - 200;
            lo = hi + int'($urandom_range(300));
         end
         4: begin
            lo = int'($signed(16'($urandom)));
            hi = int'($signed(16'($urandom)));
         end
         5: begin
            lo = int'($signed(16'($urandom)));
            hi = lo;
         end
         default: begin
            lo = 0;
            hi = 127;
         end
      endcase
      set_config(pm, 16'(lo), 16'(hi));
   endtask

   // Mostly pot sweeps, often after a load that is inside the span or random; the rest is single samples and loads.
   task automatic queue_burst(input int n);
      int made, len, step, smp;
      bit up;
      made = 0;
      while (made < n) begin
         if ($urandom_range(9) < 7) begin
            if ($urandom_range(1)) begin
               if ($urandom_range(1)) begin
                  push_load(16'(scale_pot(12'($urandom))));
               end else begin
                  push_load(16'($urandom));
               end
               made++;
            end
            smp = $urandom_range(4095);
            up = 1'($urandom_range(1));
            step = $urandom_range(1, 300);
            len = $urandom_range(4, 12);
            repeat (len) begin
               push_sample(12'(smp));
               made++;
               smp = up ? smp + step : smp - step;
               if (smp > 4095) smp = 4095;
               if (smp < 0) smp = 0;
            end
         end else if ($urandom_range(3) != 0) begin
            push_sample(12'($urandom));
            made++;
         end else begin
            push_load(16'($urandom));
            made++;
         end
      end
   endtask

   // Stimulus sequence.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Direct mode at the reset span: rails, a repeat and both load extremes.
      push_sample(12'h000);
      push_sample(12'hfff);
      push_sample(12'hfff);
      push_load(16'sh7fff);
      push_load(-16'sh8000);
      push_sample(12'd2048);
      wait_quiet;

      // Switch mode around both thresholds.
      write_csr(CSR_PICKUP_MODE, VALUE_W'(PM_SWITCH));
      push_sample(SWITCH_LOW - 12'd1);
      push_sample(SWITCH_HIGH - 12'd1);
      push_sample(SWITCH_HIGH);
      push_sample(SWITCH_LOW);
      push_sample(SAMPLE_MAX);
      push_sample(12'h000);
      wait_quiet;

      // Parallax over the full span after an outside value was loaded.
      set_config(PM_PARALLAX, 16'h8000, 16'h7fff);
      push_sample(12'hfff);
      push_load(-16'sd20000);
      push_sample(12'd1000);
      push_sample(12'd1100);
      wait_quiet;

      // Relative over a reversed full span.
      set_config(PM_RELATIVE, 16'h7fff, 16'h8000);
      push_sample(12'h000);
      push_sample(12'hfff);
      push_sample(12'h000);
      wait_quiet;

      // Snap with the stored value inside the span.
      set_config(PM_SNAP, 16'd0, 16'd127);
      push_sample(12'hfff);
      push_load(16'sd50);
      push_sample(12'd3000);
      push_sample(12'd1600);
      wait_quiet;

      // An unused pickup code with a collapsed span.
      set_config(PM_SPARE, 16'd0, 16'd0);
      push_sample(12'd1234);
      push_sample(12'h000);
      wait_quiet;

      // Random part in three idling phases.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 63 : 0;
         recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 13 : 0;
         for (int blk = 0; blk < 6; blk++) begin
            random_config();
            if (ph == 2 && blk == 0) begin
               // Fill the block while the receiver holds off.
               queue_burst(80);
               stall_kicks++;
            end else begin
               queue_burst(30);
            end
            wait_quiet;
            queue_burst(30);
            wait_quiet;
         end
      end

      recv_idle_pct = 0;
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
